/* design/assert_macros.svh */
// Assertion macros used by the checker file of the object pool block.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* design/opfl_pkg.sv */
// Package of the object pool free list: beat types, operation and status codes, states.
// Depends on nothing.
package opfl_pkg;

	localparam int SLOTS_DEF = 128;
	localparam int SLOT_W = 7;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SCRATCH = 2'd1;
	localparam logic [1:0] ST_FATAL = 2'd2;
	localparam logic [1:0] ST_OWNER = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic non_critical;
		logic [SLOT_W-1:0] slot;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [SLOT_W-1:0] given_slot;
		logic [SLOT_W-1:0] next_slot;
		logic next_valid;
		logic [SLOT_W-1:0] prev_slot;
		logic prev_valid;
	} rsp_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_FETCH,
		S_LINK
	} fsm_t;

endpackage

/* design/opfl_mem.sv */
// Link memory of the object pool: one write port and one read port, registered read data.
// Depends on nothing.
module opfl_mem #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 8
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* design/opfl_outq.sv */
// Two-entry result buffer of the object pool: output register plus one holding register.
// Depends on opfl_pkg for the result beat type.
module opfl_outq (
	input logic clk,
	input logic arst_n,
	input logic load,
	input opfl_pkg::rsp_t data,
	output logic full,
	output logic rsp_valid,
	input logic rsp_stall,
	output opfl_pkg::rsp_t rsp
);

	logic hold_v_q;
	opfl_pkg::rsp_t hold_q;
	logic out_free;

	assign out_free = !rsp_valid || !rsp_stall;
	assign full = hold_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
			hold_v_q <= 1'b0;
		end else begin
			if (out_free) begin
				rsp_valid <= hold_v_q || load;
			end
			if (load && (hold_v_q || !out_free)) begin
				hold_v_q <= 1'b1;
			end else if (out_free) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (hold_v_q) begin
				rsp <= hold_q;
			end else if (load) begin
				rsp <= data;
			end
		end
		if (load && (hold_v_q || !out_free)) begin
			hold_q <= data;
		end
	end

endmodule

/* design/object_pool_free_list_core.sv */
// Object pool free list: allocate, free and link read over two link memories.
// Allocate and free load the result register from S_LINK, after reading the links in S_FETCH,
// a read from S_FETCH, and a request that touches no memory at the accepting edge; one request
// is in flight, so a new one is taken only back in S_IDLE with the result buffer not full, as
// set by the read-then-write memory sequence. After reset a clearing pass writes every slot,
// one per cycle, while req_stall is high.
module object_pool_free_list_core #(
	parameter int SLOTS = opfl_pkg::SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input opfl_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output opfl_pkg::rsp_t rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam int LW = IW + 1;
	localparam int SW = opfl_pkg::SLOT_W;

	typedef struct packed {
		logic ok;
		logic [IW-1:0] idx;
	} link_t;

	opfl_pkg::fsm_t state_q, state_d;
	logic [IW-1:0] clr_q, clr_d;
	link_t free_head_q, free_head_d;
	link_t tail_q, tail_d;
	logic [1:0] op_q;
	logic [IW-1:0] slot_q;

	logic bl_we, fl_we;
	logic [IW-1:0] bl_waddr, fl_waddr, raddr;
	link_t bl_wdata, fl_wdata, bl_rdata, fl_rdata;

	logic accept, in_range, hold_full, res_load;
	logic [IW-1:0] slot_ix;
	logic [IW:0] clr_nxt;
	logic clr_ok;
	opfl_pkg::rsp_t res_d;

	assign req_stall = (state_q != opfl_pkg::S_IDLE) || hold_full;
	assign accept = req_valid && !req_stall;
	assign slot_ix = IW'(req.slot);
	assign in_range = 32'(req.slot) < SLOTS;
	assign raddr = (req.op == opfl_pkg::OP_ALLOC) ? free_head_q.idx : slot_ix;
	assign clr_nxt = {1'b0, clr_q} + LW'(1);
	assign clr_ok = (clr_q != '0) && (clr_nxt < LW'(SLOTS));

	opfl_mem #(.DEPTH(SLOTS), .WIDTH(LW)) u_back (
		.clk(clk),
		.we(bl_we),
		.waddr(bl_waddr),
		.wdata(bl_wdata),
		.raddr(raddr),
		.rdata(bl_rdata)
	);

	opfl_mem #(.DEPTH(SLOTS), .WIDTH(LW)) u_fwd (
		.clk(clk),
		.we(fl_we),
		.waddr(fl_waddr),
		.wdata(fl_wdata),
		.raddr(raddr),
		.rdata(fl_rdata)
	);

	opfl_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.load(res_load),
		.data(res_d),
		.full(hold_full),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= opfl_pkg::S_CLEAR;
			clr_q <= '0;
			free_head_q <= '{ok: 1'b1, idx: IW'(1)};
			tail_q <= '{ok: 1'b1, idx: '0};
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
			free_head_q <= free_head_d;
			tail_q <= tail_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req.op;
			slot_q <= raddr;
		end
	end

	always_comb begin
		state_d = state_q;
		clr_d = clr_q;
		free_head_d = free_head_q;
		tail_d = tail_q;
		bl_we = 1'b0;
		fl_we = 1'b0;
		bl_waddr = '0;
		fl_waddr = '0;
		bl_wdata = '0;
		fl_wdata = '0;
		res_load = 1'b0;
		res_d = '0;
		case (state_q)
			opfl_pkg::S_CLEAR: begin
				bl_we = 1'b1;
				fl_we = 1'b1;
				bl_waddr = clr_q;
				fl_waddr = clr_q;
				bl_wdata = '{ok: clr_ok, idx: clr_ok ? clr_nxt[IW-1:0] : '0};
				clr_d = clr_q + IW'(1);
				if (clr_q == IW'(SLOTS - 1)) begin
					state_d = opfl_pkg::S_IDLE;
				end
			end
			opfl_pkg::S_IDLE: begin
				if (accept) begin
					case (req.op)
						opfl_pkg::OP_ALLOC: begin
							if (!free_head_q.ok) begin
								res_load = 1'b1;
								res_d.status = req.non_critical ? opfl_pkg::ST_SCRATCH
									: opfl_pkg::ST_FATAL;
							end else begin
								state_d = opfl_pkg::S_FETCH;
							end
						end
						opfl_pkg::OP_FREE: begin
							if (req.slot == '0) begin
								res_load = 1'b1;
								res_d.status = opfl_pkg::ST_OWNER;
							end else if (in_range) begin
								state_d = opfl_pkg::S_FETCH;
							end else begin
								res_load = 1'b1;
							end
						end
						opfl_pkg::OP_READ: begin
							if (in_range) begin
								state_d = opfl_pkg::S_FETCH;
							end else begin
								res_load = 1'b1;
							end
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			opfl_pkg::S_FETCH: begin
				case (op_q)
					opfl_pkg::OP_ALLOC: begin
						free_head_d = bl_rdata;
						bl_we = 1'b1;
						bl_waddr = slot_q;
						bl_wdata = tail_q;
						fl_we = 1'b1;
						fl_waddr = slot_q;
						state_d = opfl_pkg::S_LINK;
					end
					opfl_pkg::OP_FREE: begin
						if (tail_q.ok && (tail_q.idx == slot_q)) begin
							tail_d = bl_rdata;
						end else if (fl_rdata.ok) begin
							bl_we = 1'b1;
							bl_waddr = fl_rdata.idx;
							bl_wdata = bl_rdata;
						end
						if (bl_rdata.ok) begin
							fl_we = 1'b1;
							fl_waddr = bl_rdata.idx;
							fl_wdata = fl_rdata;
						end
						state_d = opfl_pkg::S_LINK;
					end
					default: begin
						res_load = 1'b1;
						res_d.next_slot = SW'(fl_rdata.idx);
						res_d.next_valid = fl_rdata.ok;
						res_d.prev_slot = SW'(bl_rdata.idx);
						res_d.prev_valid = bl_rdata.ok;
						state_d = opfl_pkg::S_IDLE;
					end
				endcase
			end
			opfl_pkg::S_LINK: begin
				res_load = 1'b1;
				state_d = opfl_pkg::S_IDLE;
				if (op_q == opfl_pkg::OP_ALLOC) begin
					if (tail_q.ok) begin
						fl_we = 1'b1;
						fl_waddr = tail_q.idx;
						fl_wdata = '{ok: 1'b1, idx: slot_q};
					end
					tail_d = '{ok: 1'b1, idx: slot_q};
					res_d.given_slot = SW'(slot_q);
				end else begin
					bl_we = 1'b1;
					bl_waddr = slot_q;
					bl_wdata = free_head_q;
					free_head_d = '{ok: 1'b1, idx: slot_q};
				end
			end
			default: begin
				state_d = opfl_pkg::S_IDLE;
			end
		endcase
	end

endmodule

/* design/opfl_chk.sv */
// Port checker of the object pool free list, bound to the top level.
// Depends on opfl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module opfl_chk (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input opfl_pkg::req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input opfl_pkg::rsp_t rsp
);

	logic [1:0] pend_q;
	logic in_beat, out_beat;
	logic empty_rsp, empty_zero, none_zero;

	assign in_beat = req_valid && !req_stall;
	assign out_beat = rsp_valid && !rsp_stall;
	assign empty_rsp = rsp_valid && (rsp.status == opfl_pkg::ST_SCRATCH
		|| rsp.status == opfl_pkg::ST_FATAL);
	assign empty_zero = (rsp.given_slot == '0) && !rsp.next_valid && !rsp.prev_valid;
	assign none_zero = (rsp.next_valid || rsp.next_slot == '0)
		&& (rsp.prev_valid || rsp.prev_slot == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_beat && !out_beat) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_beat && !in_beat) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	`ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`ASSERT_IMP(a_no_phantom, clk, arst_n, rsp_valid, pend_q != 2'd0)
	`ASSERT_IMP(a_accept_room, clk, arst_n, in_beat, pend_q < 2'd2)
	`ASSERT_IMP(a_empty_pool, clk, arst_n, empty_rsp, empty_zero)
	`ASSERT_IMP(a_none_link, clk, arst_n, rsp_valid, none_zero)

endmodule

bind object_pool_free_list_core opfl_chk u_chk (.*);

/* sim/object_pool_free_list_core_tb.sv */
// Self-checking testbench of object_pool_free_list_core: a short table of directed beats, then
// random allocate, free and read traffic checked against a model of the pool kept here.
// Depends on opfl_pkg and the object_pool_free_list_core RTL.
module object_pool_free_list_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = opfl_pkg::SLOTS_DEF;
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam opfl_pkg::rsp_t RSP_ZERO = '0;

	typedef struct packed {
		logic ok;
		logic [7:0] idx;
	} link_t;

	typedef struct {
		opfl_pkg::req_t r;
		bit typed;
		opfl_pkg::rsp_t want;
	} row_t;

	localparam link_t NO_LINK = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	opfl_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	opfl_pkg::rsp_t rsp;

	link_t pool_back[SLOTS];
	link_t pool_fwd[SLOTS];
	link_t pool_free_head;
	link_t pool_tail;

	opfl_pkg::rsp_t pool_rsp_q[$];
	int live_slots[$];
	row_t dir_rows[$];

	int send_idle_pct = 0;
	int rcv_idle_pct = 0;
	int err_cnt = 0;
	int checked_cnt = 0;
	int n_alloc = 0;
	int n_free = 0;
	int n_read = 0;
	int n_empty = 0;
	int n_owner = 0;
	int n_unused = 0;
	bit filling = 1'b0;
	bit draining = 1'b0;
	int fill_extra = 0;
	int fill_cnt = 0;

	object_pool_free_list_core #(
		.SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #6 clk = ~clk;

	task automatic pool_reset();
		for (int i = 0; i < SLOTS; i++) begin
			pool_back[i] = (i + 1 < SLOTS) ? link_t'{1'b1, 8'(i + 1)} : NO_LINK;
			pool_fwd[i] = NO_LINK;
		end
		pool_back[0] = NO_LINK;
		pool_free_head = link_t'{1'b1, 8'd1};
		pool_tail = link_t'{1'b1, 8'd0};
	endtask

	function automatic bit pool_empty();
		return !pool_free_head.ok || pool_free_head.idx >= SLOTS;
	endfunction

	function automatic opfl_pkg::rsp_t pool_apply(input opfl_pkg::req_t r);
		opfl_pkg::rsp_t o;
		link_t b;
		link_t f;
		int unsigned s;
		o = '0;
		s = 32'(r.slot);
		case (r.op)
		opfl_pkg::OP_ALLOC: begin
			if (pool_empty()) begin
				o.status = r.non_critical ? opfl_pkg::ST_SCRATCH : opfl_pkg::ST_FATAL;
			end else begin
				s = 32'(pool_free_head.idx);
				pool_free_head = pool_back[s];
				pool_fwd[s] = NO_LINK;
				if (pool_tail.ok && pool_tail.idx < SLOTS)
					pool_fwd[pool_tail.idx] = link_t'{1'b1, 8'(s)};
				pool_back[s] = pool_tail;
				pool_tail = link_t'{1'b1, 8'(s)};
				o.given_slot = s[6:0];
			end
		end
		opfl_pkg::OP_FREE: begin
			if (s == 0) begin
				o.status = opfl_pkg::ST_OWNER;
			end else if (s < SLOTS) begin
				b = pool_back[s];
				f = pool_fwd[s];
				if (pool_tail.ok && pool_tail.idx == s)
					pool_tail = b;
				else if (f.ok && f.idx < SLOTS)
					pool_back[f.idx] = b;
				if (b.ok && b.idx < SLOTS)
					pool_fwd[b.idx] = f;
				pool_back[s] = pool_free_head;
				pool_free_head = link_t'{1'b1, 8'(s)};
			end
		end
		opfl_pkg::OP_READ: begin
			if (s < SLOTS) begin
				o.next_slot = pool_fwd[s].idx[6:0];
				o.next_valid = pool_fwd[s].ok;
				o.prev_slot = pool_back[s].idx[6:0];
				o.prev_valid = pool_back[s].ok;
			end
		end
		default: begin
		end
		endcase
		return o;
	endfunction

	function automatic row_t mk_row(input logic [1:0] op, input logic nc, input logic [6:0] slot,
			input bit typed, input opfl_pkg::rsp_t want);
		row_t w;
		w.r = opfl_pkg::req_t'{op, nc, slot};
		w.typed = typed;
		w.want = want;
		return w;
	endfunction

	function automatic int pick_live();
		if (live_slots.size() == 0)
			return int'($urandom_range(SLOTS - 1));
		return live_slots[$urandom_range(live_slots.size() - 1)];
	endfunction

	function automatic opfl_pkg::req_t gen_req();
		opfl_pkg::req_t r;
		int pick;
		r.non_critical = 1'($urandom_range(1));
		r.slot = 7'($urandom_range(SLOTS - 1));
		r.op = opfl_pkg::OP_READ;
		pick = int'($urandom_range(99));
		if (filling) begin
			fill_cnt++;
			if (pick < 5) begin
				r.slot = 7'(pick_live());
			end else begin
				r.op = opfl_pkg::OP_ALLOC;
				if (pool_empty())
					fill_extra--;
			end
			if (fill_extra <= 0 || fill_cnt > 150) begin
				filling = 1'b0;
				draining = 1'b1;
			end
		end else if (draining) begin
			if (live_slots.size() > 6 && pick < 92) begin
				r.op = opfl_pkg::OP_FREE;
				r.slot = 7'(pick_live());
			end else if (live_slots.size() <= 6) begin
				draining = 1'b0;
			end
		end else if (pick < 40) begin
			r.op = opfl_pkg::OP_ALLOC;
		end else if (pick < 65) begin
			r.op = opfl_pkg::OP_FREE;
			r.slot = 7'(pick_live());
		end else if (pick < 70) begin
			r.op = opfl_pkg::OP_FREE;
		end else if (pick < 95) begin
			if (pick < 82)
				r.slot = 7'(pick_live());
		end else begin
			r.op = OP_NONE;
		end
		return r;
	endfunction

	task automatic note_beat(input opfl_pkg::req_t r, input opfl_pkg::rsp_t p);
		case (r.op)
		opfl_pkg::OP_ALLOC: begin
			n_alloc++;
			if (p.status == opfl_pkg::ST_OK)
				live_slots.push_back(int'(p.given_slot));
			else
				n_empty++;
		end
		opfl_pkg::OP_FREE: begin
			n_free++;
			if (p.status == opfl_pkg::ST_OWNER)
				n_owner++;
			for (int i = live_slots.size() - 1; i >= 0; i--)
				if (live_slots[i] == int'(r.slot))
					live_slots.delete(i);
		end
		opfl_pkg::OP_READ: n_read++;
		default: n_unused++;
		endcase
	endtask

	task automatic send_beat(input opfl_pkg::req_t r, input bit typed,
			input opfl_pkg::rsp_t want);
		opfl_pkg::rsp_t p;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (req_stall);
		p = pool_apply(r);
		note_beat(r, p);
		pool_rsp_q.push_back(typed ? want : p);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		err_cnt++;
		$display("%0t: result %0d, %s: got %0d, expected %0d", $realtime, checked_cnt, what,
				got, want);
	endtask

	task automatic check_rsp(input opfl_pkg::rsp_t got, input opfl_pkg::rsp_t want);
		if (got.status != want.status)
			report_mismatch("status", got.status, want.status);
		if (got.given_slot != want.given_slot)
			report_mismatch("given_slot", got.given_slot, want.given_slot);
		if (got.next_slot != want.next_slot)
			report_mismatch("next_slot", got.next_slot, want.next_slot);
		if (got.next_valid != want.next_valid)
			report_mismatch("next_valid", got.next_valid, want.next_valid);
		if (got.prev_slot != want.prev_slot)
			report_mismatch("prev_slot", got.prev_slot, want.prev_slot);
		if (got.prev_valid != want.prev_valid)
			report_mismatch("prev_valid", got.prev_valid, want.prev_valid);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pool_rsp_q.size() == 0) begin
				report_mismatch("beat with nothing expected, status", rsp.status, -1);
			end else begin
				check_rsp(rsp, pool_rsp_q.pop_front());
			end
			checked_cnt++;
		end
		rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
	end

	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end

	initial begin
		pool_reset();
		dir_rows.push_back(mk_row(opfl_pkg::OP_READ, 1'b0, 7'd0, 1'b1, RSP_ZERO));
		dir_rows.push_back(mk_row(opfl_pkg::OP_READ, 1'b1, 7'd127, 1'b1, RSP_ZERO));
		dir_rows.push_back(mk_row(opfl_pkg::OP_READ, 1'b0, 7'd1, 1'b1,
				opfl_pkg::rsp_t'{opfl_pkg::ST_OK, 7'd0, 7'd0, 1'b0, 7'd2, 1'b1}));
		dir_rows.push_back(mk_row(opfl_pkg::OP_FREE, 1'b1, 7'd0, 1'b1,
				opfl_pkg::rsp_t'{opfl_pkg::ST_OWNER, 7'd0, 7'd0, 1'b0, 7'd0, 1'b0}));
		dir_rows.push_back(mk_row(OP_NONE, 1'b1, 7'd127, 1'b1, RSP_ZERO));
		dir_rows.push_back(mk_row(opfl_pkg::OP_ALLOC, 1'b0, 7'd0, 1'b1,
				opfl_pkg::rsp_t'{opfl_pkg::ST_OK, 7'd1, 7'd0, 1'b0, 7'd0, 1'b0}));
		dir_rows.push_back(mk_row(opfl_pkg::OP_ALLOC, 1'b1, 7'd127, 1'b1,
				opfl_pkg::rsp_t'{opfl_pkg::ST_OK, 7'd2, 7'd0, 1'b0, 7'd0, 1'b0}));
		dir_rows.push_back(mk_row(opfl_pkg::OP_ALLOC, 1'b0, 7'd85, 1'b1,
				opfl_pkg::rsp_t'{opfl_pkg::ST_OK, 7'd3, 7'd0, 1'b0, 7'd0, 1'b0}));
		dir_rows.push_back(mk_row(opfl_pkg::OP_READ, 1'b0, 7'd2, 1'b0, RSP_ZERO));
		dir_rows.push_back(mk_row(opfl_pkg::OP_FREE, 1'b0, 7'd2, 1'b0, RSP_ZERO));
		dir_rows.push_back(mk_row(opfl_pkg::OP_READ, 1'b1, 7'd1, 1'b0, RSP_ZERO));
		dir_rows.push_back(mk_row(opfl_pkg::OP_FREE, 1'b1, 7'd3, 1'b0, RSP_ZERO));
		dir_rows.push_back(mk_row(opfl_pkg::OP_READ, 1'b0, 7'd2, 1'b0, RSP_ZERO));
		dir_rows.push_back(mk_row(opfl_pkg::OP_ALLOC, 1'b1, 7'd42, 1'b0, RSP_ZERO));
		dir_rows.push_back(mk_row(opfl_pkg::OP_FREE, 1'b0, 7'd4, 1'b0, RSP_ZERO));
		dir_rows.push_back(mk_row(opfl_pkg::OP_READ, 1'b0, 7'd4, 1'b0, RSP_ZERO));
		dir_rows.push_back(mk_row(opfl_pkg::OP_READ, 1'b1, 7'd0, 1'b0, RSP_ZERO));
		dir_rows.push_back(mk_row(opfl_pkg::OP_ALLOC, 1'b1, 7'd0, 1'b0, RSP_ZERO));
		dir_rows.push_back(mk_row(opfl_pkg::OP_ALLOC, 1'b0, 7'd127, 1'b0, RSP_ZERO));
		dir_rows.push_back(mk_row(opfl_pkg::OP_FREE, 1'b1, 7'd1, 1'b0, RSP_ZERO));
		dir_rows.push_back(mk_row(opfl_pkg::OP_READ, 1'b0, 7'd0, 1'b0, RSP_ZERO));
		dir_rows.push_back(mk_row(OP_NONE, 1'b0, 7'd0, 1'b0, RSP_ZERO));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 8;
		rcv_idle_pct = 78;
		foreach (dir_rows[i])
			send_beat(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].want);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 78 : 0;
			rcv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 8 : 0;
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while (pool_rsp_q.size() != 0);
			if (ph == 1) begin
				filling = 1'b1;
				fill_extra = 4;
				fill_cnt = 0;
			end
			repeat (134)
				send_beat(gen_req(), 1'b0, RSP_ZERO);
		end

		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (pool_rsp_q.size() != 0);
		repeat (20) @(posedge clk);
		if (pool_rsp_q.size() != 0)
			report_mismatch("results still outstanding", 0, pool_rsp_q.size());

		$display("Covered %0d allocations (%0d on an empty pool), %0d frees (%0d of the owner),",
				n_alloc, n_empty, n_free, n_owner);
		$display("%0d link reads and %0d unused operations; %0d results checked, %0d mismatches.",
				n_read, n_unused, checked_cnt, err_cnt);
		if (err_cnt == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
